>>> hdl/tfn_pkg.sv
package tfn_pkg;

  localparam int unsigned CoordBitsDef = 32;
  localparam int unsigned FracBitsDef  = 14;

  // Internal widths follow the widest coordinate; narrower coordinates are sign-extended.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = 2 * DiffW;
  localparam int unsigned CrossW  = 66;
  localparam int unsigned MagW    = 65;
  localparam int unsigned LenW    = 7;
  localparam int unsigned MW      = 31;
  localparam int unsigned SqW     = 2 * MW;
  localparam int unsigned SumW    = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned SqrtSteps = 32;

  localparam logic [LenW-1:0] TargetLen = LenW'(MW);
  localparam logic [8:0]      DegenMag  = 9'd429;
  localparam logic [19:0]     DegenSqLimit = 20'd184467;
  localparam logic [14:0]     NormSatMax = 15'h7fff;

  typedef struct packed {
    logic [2:0] neg;
    logic       degen;
  } tfn_flags_t;

  typedef struct packed {
    logic [2:0][MW-1:0] m;
    tfn_flags_t         flags;
  } tfn_vec_t;

  // Bit length of a magnitude: index of the highest set bit plus one, zero for zero.
  function automatic logic [LenW-1:0] bit_len(input logic [MagW-1:0] v);
    logic [LenW-1:0] n;
    n = '0;
    for (int i = 0; i < MagW; i++) begin
      if (v[i]) n = LenW'(i + 1);
    end
    return n;
  endfunction

endpackage

>>> hdl/tfn_front.sv
module tfn_front #(
  parameter int unsigned CoordBits = tfn_pkg::CoordBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [8:0][31:0]            coord_i,
  output logic                        valid_o,
  output logic [tfn_pkg::SumW-1:0]    sum_o,
  output tfn_pkg::tfn_vec_t           vec_o
);
  import tfn_pkg::*;

  logic [6:0] v_q;

  logic [8:0][CoordW-1:0]         p;
  logic signed [2:0][DiffW-1:0]   d1_q, d2_q;
  logic signed [5:0][ProdW-1:0]   prod_q;
  logic signed [2:0][CrossW-1:0]  cross_q;
  logic [2:0][MagW-1:0]           mag3_q, mag4_q;
  logic [2:0]                     neg3_q, neg4_q, neg5_q, neg6_q;
  logic [LenW-1:0]                len_q;
  logic                           degen4_q, degen5_q, degen6_q;
  logic [2:0][MW-1:0]             m5_q, m6_q;
  logic [2:0][SqW-1:0]            sq_q;
  logic [SumW-1:0]                sum_q;
  tfn_vec_t                       vec_q;
  logic                           valid_q;

  logic [2:0][MagW-1:0]           mag_abs;
  logic [MagW-1:0]                mag_or;
  logic [2:0][17:0]               small_sq;
  logic [19:0]                    small_sum;
  logic                           small_all;
  logic [2:0][MW-1:0]             m_d;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      p[i] = CoordW'($signed(coord_i[i][CoordBits-1:0]));
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_abs[i] = cross_q[i][CrossW-1] ? MagW'(-cross_q[i]) : MagW'(cross_q[i]);
    end
  end

  always_comb begin
    mag_or    = mag3_q[0] | mag3_q[1] | mag3_q[2];
    small_all = 1'b1;
    for (int i = 0; i < 3; i++) begin
      small_all   = small_all && (mag3_q[i] <= MagW'(DegenMag));
      small_sq[i] = mag3_q[i][8:0] * mag3_q[i][8:0];
    end
    small_sum = 20'(small_sq[0]) + 20'(small_sq[1]) + 20'(small_sq[2]);
  end

  // Scale so that the largest magnitude has exactly MW bits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (len_q > TargetLen) begin
        m_d[i] = MW'(mag4_q[i] >> (len_q - TargetLen));
      end else begin
        m_d[i] = MW'(mag4_q[i] << (TargetLen - len_q));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      valid_q <= 1'b0;
    end else if (en_i) begin
      v_q     <= {v_q[5:0], valid_i};
      valid_q <= v_q[6];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= $signed(DiffW'($signed(p[3+i]))) - $signed(DiffW'($signed(p[i])));
        d2_q[i] <= $signed(DiffW'($signed(p[6+i]))) - $signed(DiffW'($signed(p[i])));
      end
      prod_q[0] <= $signed(d1_q[1]) * $signed(d2_q[2]);
      prod_q[1] <= $signed(d1_q[2]) * $signed(d2_q[1]);
      prod_q[2] <= $signed(d1_q[2]) * $signed(d2_q[0]);
      prod_q[3] <= $signed(d1_q[0]) * $signed(d2_q[2]);
      prod_q[4] <= $signed(d1_q[0]) * $signed(d2_q[1]);
      prod_q[5] <= $signed(d1_q[1]) * $signed(d2_q[0]);
      for (int i = 0; i < 3; i++) begin
        cross_q[i] <= CrossW'(prod_q[2*i]) - CrossW'(prod_q[2*i+1]);
        neg3_q[i]  <= cross_q[i][CrossW-1];
        mag3_q[i]  <= mag_abs[i];
      end
      len_q    <= bit_len(mag_or);
      degen4_q <= small_all && (small_sum <= DegenSqLimit);
      mag4_q   <= mag3_q;
      neg4_q   <= neg3_q;
      m5_q     <= m_d;
      neg5_q   <= neg4_q;
      degen5_q <= degen4_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= m5_q[i] * m5_q[i];
      end
      m6_q     <= m5_q;
      neg6_q   <= neg5_q;
      degen6_q <= degen5_q;
      sum_q    <= SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
      vec_q.m  <= m6_q;
      vec_q.flags.neg   <= neg6_q;
      vec_q.flags.degen <= degen6_q;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign vec_o   = vec_q;

endmodule

>>> hdl/tfn_sqrt_cell.sv
module tfn_sqrt_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     valid_i,
  input  logic [tfn_pkg::SumW-1:0] rem_i,
  input  logic [tfn_pkg::SumW-1:0] res_i,
  input  tfn_pkg::tfn_vec_t        vec_i,
  output logic                     valid_o,
  output logic [tfn_pkg::SumW-1:0] rem_o,
  output logic [tfn_pkg::SumW-1:0] res_o,
  output tfn_pkg::tfn_vec_t        vec_o
);
  import tfn_pkg::*;

  localparam logic [SumW-1:0] StepBit = SumW'(1) << (SumW - 2 - 2 * Idx);

  logic            valid_q;
  logic [SumW-1:0] rem_q, res_q, trial;
  tfn_vec_t        vec_q;
  logic            take;

  assign trial = res_i + StepBit;
  assign take  = rem_i >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= take ? rem_i - trial : rem_i;
      res_q <= take ? (res_i >> 1) + StepBit : res_i >> 1;
      vec_q <= vec_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign res_o   = res_q;
  assign vec_o   = vec_q;

endmodule

>>> hdl/tfn_div_cell.sv
module tfn_div_cell #(
  parameter int unsigned QBits = tfn_pkg::FracBitsDef + 2
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [tfn_pkg::RootW-1:0]          root_i,
  input  logic [2:0][tfn_pkg::RootW-1:0]     rem_i,
  input  logic [2:0][QBits-1:0]              num_i,
  input  logic [2:0][QBits-1:0]              quo_i,
  input  tfn_pkg::tfn_flags_t                flags_i,
  output logic                               valid_o,
  output logic [tfn_pkg::RootW-1:0]          root_o,
  output logic [2:0][tfn_pkg::RootW-1:0]     rem_o,
  output logic [2:0][QBits-1:0]              num_o,
  output logic [2:0][QBits-1:0]              quo_o,
  output tfn_pkg::tfn_flags_t                flags_o
);
  import tfn_pkg::*;

  logic                      valid_q;
  logic [RootW-1:0]          root_q;
  logic [2:0][RootW-1:0]     rem_q;
  logic [2:0][QBits-1:0]     num_q, quo_q;
  tfn_flags_t                flags_q;
  logic [2:0][RootW:0]       trial;
  logic [2:0][RootW:0]       diff;
  logic [2:0]                take;

  // One restoring step per lane: bring down the next numerator bit and subtract if it fits.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trial[i] = {rem_i[i], num_i[i][QBits-1]};
      take[i]  = trial[i] >= {1'b0, root_i};
      diff[i]  = trial[i] - {1'b0, root_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q  <= root_i;
      flags_q <= flags_i;
      for (int i = 0; i < 3; i++) begin
        rem_q[i] <= take[i] ? diff[i][RootW-1:0] : trial[i][RootW-1:0];
        num_q[i] <= num_i[i] << 1;
        quo_q[i] <= {quo_i[i][QBits-2:0], take[i]};
      end
    end
  end

  assign valid_o = valid_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;
  assign num_o   = num_q;
  assign quo_o   = quo_q;
  assign flags_o = flags_q;

endmodule

>>> hdl/triangle_face_normal.sv
// Triangle face normal.
// The slave stream carries one triangle per transfer: nine signed Q16.16 coordinates
// (a, b, c vertices, x then y then z). The master stream returns one transfer per
// triangle: the unit face normal in signed Q2.14 in tdata and a degenerate flag in tuser.
// The block forms the cross product of the edges b - a and c - a, normalises
// it to 31 bits, takes the square root of the sum of squares through a row of 32
// identical root cells (one result bit each) and divides every component by the
// length through a row of NORMAL_FRAC_BITS + 2 divider cells (one quotient bit each).
// Throughput is one triangle per cycle unless the receiver stalls, set by the cell rows,
// which are fully pipelined.
// When the cross product length is at or below 1e-7 the normal is zero and the
// degenerate flag is raised.
// Reset clears only the valid bits of the pipeline; the data registers are not reset.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// s_tready_o falls; it rises again in the cycle the result is taken.
module triangle_face_normal #(
  parameter int unsigned COORD_BITS       = tfn_pkg::CoordBitsDef,
  parameter int unsigned NORMAL_FRAC_BITS = tfn_pkg::FracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 32 bits each from the lowest bit up.
  input  logic [287:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // norm_x [15:0], norm_y [31:16], norm_z [47:32].
  output logic [47:0]  m_tdata_o,
  // degenerate.
  output logic         m_tuser_o
);
  import tfn_pkg::*;

  localparam int unsigned QBits = NORMAL_FRAC_BITS + 2;
  localparam int unsigned NumW  = NORMAL_FRAC_BITS + MW + 1;
  localparam int unsigned QW    = (QBits > 16) ? QBits : 16;

  logic en;
  logic out_valid_q;

  // The pipeline advances whenever the output register is free or being emptied.
  assign en         = !out_valid_q || m_tready_i;
  assign s_tready_o = en;

  logic [8:0][31:0] coord;
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      coord[i] = s_tdata_i[32*i +: 32];
    end
  end

  logic            front_valid;
  logic [SumW-1:0] front_sum;
  tfn_vec_t        front_vec;

  tfn_front #(
    .CoordBits(COORD_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_tvalid_i && en),
    .coord_i(coord),
    .valid_o(front_valid),
    .sum_o  (front_sum),
    .vec_o  (front_vec)
  );

  // Square-root row.
  logic [SqrtSteps:0]           sq_valid;
  logic [SqrtSteps:0][SumW-1:0] sq_rem, sq_res;
  tfn_vec_t [SqrtSteps:0]       sq_vec;

  assign sq_valid[0] = front_valid;
  assign sq_rem[0]   = front_sum;
  assign sq_res[0]   = '0;
  assign sq_vec[0]   = front_vec;

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    tfn_sqrt_cell #(
      .Idx(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sq_valid[k]),
      .rem_i  (sq_rem[k]),
      .res_i  (sq_res[k]),
      .vec_i  (sq_vec[k]),
      .valid_o(sq_valid[k+1]),
      .rem_o  (sq_rem[k+1]),
      .res_o  (sq_res[k+1]),
      .vec_o  (sq_vec[k+1])
    );
  end

  // Rounded dividend (m << F) + L / 2, split into the starting remainder and the bits
  // still to be brought down.
  logic [RootW-1:0]     root;
  logic [2:0][NumW-1:0] numer;

  assign root = sq_res[SqrtSteps][RootW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      numer[i] = (NumW'(sq_vec[SqrtSteps].m[i]) << NORMAL_FRAC_BITS)
               + NumW'(root >> 1);
    end
  end

  logic [QBits:0]                 dv_valid;
  logic [QBits:0][RootW-1:0]      dv_root;
  logic [QBits:0][2:0][RootW-1:0] dv_rem;
  logic [QBits:0][2:0][QBits-1:0] dv_num, dv_quo;
  tfn_flags_t [QBits:0]           dv_flags;
  logic                           prep_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= sq_valid[SqrtSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_root[0]  <= root;
      dv_flags[0] <= sq_vec[SqrtSteps].flags;
      for (int i = 0; i < 3; i++) begin
        dv_rem[0][i] <= RootW'(numer[i][NumW-1:QBits]);
        dv_num[0][i] <= numer[i][QBits-1:0];
      end
    end
  end

  assign dv_valid[0] = prep_valid_q;
  assign dv_quo[0]   = '0;

  for (genvar k = 0; k < QBits; k++) begin : g_div
    tfn_div_cell #(
      .QBits(QBits)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv_valid[k]),
      .root_i (dv_root[k]),
      .rem_i  (dv_rem[k]),
      .num_i  (dv_num[k]),
      .quo_i  (dv_quo[k]),
      .flags_i(dv_flags[k]),
      .valid_o(dv_valid[k+1]),
      .root_o (dv_root[k+1]),
      .rem_o  (dv_rem[k+1]),
      .num_o  (dv_num[k+1]),
      .quo_o  (dv_quo[k+1]),
      .flags_o(dv_flags[k+1])
    );
  end

  // Saturate, apply the sign and force a zero normal for a degenerate triangle.
  logic [2:0][QW-1:0] quo_ext;
  logic [2:0][14:0]   quo_sat;
  logic [2:0][15:0]   norm_d;
  logic [47:0]        data_q;
  logic               degen_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      quo_ext[i] = QW'(dv_quo[QBits][i]);
      quo_sat[i] = (quo_ext[i] > QW'(NormSatMax)) ? NormSatMax : quo_ext[i][14:0];
      if (dv_flags[QBits].degen) begin
        norm_d[i] = '0;
      end else if (dv_flags[QBits].neg[i]) begin
        norm_d[i] = -{1'b0, quo_sat[i]};
      end else begin
        norm_d[i] = {1'b0, quo_sat[i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid[QBits];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      data_q  <= {norm_d[2], norm_d[1], norm_d[0]};
      degen_q <= dv_flags[QBits].degen;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = degen_q;

endmodule
